[rtl/iis_pkg.sv]
package iis_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned AREA_W    = 28;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned DIM_CMP_W = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic first_row;
    logic row_end;
    logic frame_end;
  } pix_flags_t;

endpackage

[rtl/iis_pixel_if.sv]
interface iis_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [iis_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

[rtl/iis_result_if.sv]
interface iis_result_if;
  logic                       valid;
  logic                       ready;
  logic [iis_pkg::AREA_W-1:0] area_sum;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, output area_sum, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input area_sum, input row_end, input frame_end,
                output ready);
endinterface

[rtl/iis_cfg_if.sv]
interface iis_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [iis_pkg::CFG_IDX_W-1:0] index;
  logic [iis_pkg::DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/iis_front.sv]
module iis_front #(
  parameter int unsigned MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned COL_W      = $clog2(MAX_WIDTH),
  parameter int unsigned SUM_W      = $clog2(MAX_WIDTH * 255 + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  iis_pixel_if.sink           pix_i,
  iis_cfg_if.sink             cfg_i,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output logic [SUM_W-1:0]    q_sum_o,
  output logic [COL_W-1:0]    q_col_o,
  output iis_pkg::pix_flags_t q_flags_o
);
  import iis_pkg::*;

  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  logic [DIM_CMP_W-1:0] width_q, height_q;
  logic [DIM_CMP_W-1:0] w_eff, h_eff;
  logic [DIM_CMP_W-1:0] col_inc, row_inc;
  logic [COL_W-1:0]     col_q;
  logic [ROW_W-1:0]     row_q;
  logic [SUM_W-1:0]     row_sum_q;
  logic [SUM_W-1:0]     sum;
  logic                 last_col, last_row;
  logic                 accept;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_CMP_W'(1);
    end else if (width_q > DIM_CMP_W'(MAX_WIDTH)) begin
      w_eff = DIM_CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_CMP_W'(1);
    end else if (height_q > DIM_CMP_W'(MAX_HEIGHT)) begin
      h_eff = DIM_CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign col_inc  = DIM_CMP_W'(col_q) + DIM_CMP_W'(1);
  assign row_inc  = DIM_CMP_W'(row_q) + DIM_CMP_W'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);
  assign sum      = row_sum_q + SUM_W'(pix_i.pixel);

  assign accept      = pix_i.valid && q_ready_i;
  assign pix_i.ready = q_ready_i;
  assign cfg_i.ready = 1'b1;

  assign q_push_o            = accept;
  assign q_sum_o             = sum;
  assign q_col_o             = col_q;
  assign q_flags_o.first_row = (row_q == '0);
  assign q_flags_o.row_end   = last_col;
  assign q_flags_o.frame_end = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_CMP_W'(MAX_WIDTH);
      height_q  <= DIM_CMP_W'(MAX_HEIGHT);
      col_q     <= '0;
      row_q     <= '0;
      row_sum_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:  width_q  <= DIM_CMP_W'(cfg_i.data);
          CFG_IMAGE_HEIGHT: height_q <= DIM_CMP_W'(cfg_i.data);
          default: ;
        endcase
      end
      if (accept) begin
        if (last_col) begin
          col_q     <= '0;
          row_sum_q <= '0;
          row_q     <= last_row ? '0 : ROW_W'(row_inc);
        end else begin
          col_q     <= COL_W'(col_inc);
          row_sum_q <= sum;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_col |=> col_q == '0 && row_sum_q == '0)
    else $error("column counter did not wrap at row end");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_col && last_row |=> row_q == '0)
    else $error("row counter did not wrap at frame end");
`endif

endmodule

[rtl/iis_fifo.sv]
module iis_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue holds more words than it has slots");
`endif

endmodule

[rtl/iis_back.sv]
module iis_back #(
  parameter int unsigned MAX_WIDTH = iis_pkg::DEF_MAX_WIDTH,
  parameter int unsigned COL_W     = $clog2(MAX_WIDTH),
  parameter int unsigned SUM_W     = $clog2(MAX_WIDTH * 255 + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  logic [SUM_W-1:0]    q_sum_i,
  input  logic [COL_W-1:0]    q_col_i,
  input  iis_pkg::pix_flags_t q_flags_i,
  output logic                q_pop_o,
  iis_result_if.source        res_o
);
  import iis_pkg::*;

  logic [AREA_W-1:0] line_mem [MAX_WIDTH];

  logic              s2_valid_q;
  logic [SUM_W-1:0]  s2_sum_q;
  logic [COL_W-1:0]  s2_col_q;
  pix_flags_t        s2_flags_q;
  logic [AREA_W-1:0] rd_q;
  logic              fwd_q;
  logic [AREA_W-1:0] fwd_data_q;

  logic              out_valid_q;
  logic [AREA_W-1:0] out_area_q;
  logic              out_row_end_q, out_frame_end_q;

  logic              s2_fire;
  logic [AREA_W-1:0] above, total;

  assign s2_fire = s2_valid_q && (!out_valid_q || res_o.ready);
  assign q_pop_o = !q_empty_i && (!s2_valid_q || s2_fire);

  always_comb begin
    if (s2_flags_q.first_row) begin
      above = '0;
    end else if (fwd_q) begin
      above = fwd_data_q;
    end else begin
      above = rd_q;
    end
  end

  assign total = AREA_W'(s2_sum_q) + above;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      line_mem[s2_col_q] <= total;
    end
    if (q_pop_o) begin
      rd_q <= line_mem[q_col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s2_valid_q <= 1'b1;
        fwd_q      <= s2_fire && (s2_col_q == q_col_i);
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s2_sum_q   <= q_sum_i;
      s2_col_q   <= q_col_i;
      s2_flags_q <= q_flags_i;
      fwd_data_q <= total;
    end
    if (s2_fire) begin
      out_area_q      <= total;
      out_row_end_q   <= s2_flags_q.row_end;
      out_frame_end_q <= s2_flags_q.frame_end;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.area_sum  = out_area_q;
  assign res_o.row_end   = out_row_end_q;
  assign res_o.frame_end = out_frame_end_q;

`ifndef SYNTHESIS
  a_frame_implies_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_frame_end_q |-> out_row_end_q)
    else $error("frame end flagged on a word that does not end its row");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_fire |=> s2_valid_q && $stable(s2_col_q))
    else $error("stalled line-store stage lost its word");
`endif

endmodule

[rtl/integral_image_stream.sv]
// Channel   Direction  Payload                          Handshake
// pix_i     in         pixel[7:0]                       valid / ready
// cfg_i     in         index[1:0], data[10:0]           valid / ready (always ready)
// res_o     out        area_sum[27:0], row_end, frame_end  valid / ready
//
// One pixel is taken per clock cycle while the queue is not full; a taken pixel is written
// into the queue, then moved from the queue into the line-store read stage, then into
// the output register. Reset clears the counters, the row sum and the handshake state.
// The front and back halves are parted by a two-word queue, so either side may stall.
module integral_image_stream #(
  parameter int unsigned MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iis_pixel_if.sink    pix_i,
  iis_cfg_if.sink      cfg_i,
  iis_result_if.source res_o
);
  import iis_pkg::*;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned SUM_W   = $clog2(MAX_WIDTH * 255 + 1);
  localparam int unsigned FLAGS_W = $bits(pix_flags_t);
  localparam int unsigned Q_W     = FLAGS_W + COL_W + SUM_W;

  logic             q_push, q_full, q_pop, q_empty;
  logic [SUM_W-1:0] f_sum, b_sum;
  logic [COL_W-1:0] f_col, b_col;
  pix_flags_t       f_flags, b_flags;
  logic [Q_W-1:0]   q_in, q_out;

  iis_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .cfg_i     (cfg_i),
    .q_ready_i (!q_full),
    .q_push_o  (q_push),
    .q_sum_o   (f_sum),
    .q_col_o   (f_col),
    .q_flags_o (f_flags)
  );

  assign q_in = {f_flags, f_col, f_sum};

  iis_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  assign {b_flags, b_col, b_sum} = q_out;

  iis_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .SUM_W     (SUM_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_sum_i   (b_sum),
    .q_col_i   (b_col),
    .q_flags_i (b_flags),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule
